/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_RESULT
  } tcw_state_t;

endpackage

`default_nettype wire

/* src/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: a ROWS x COLUMNS grid of character/attribute cells and a
// cursor, driven by put-character, clear-screen and read-cell requests.
//
// Usage: a request on in_data is taken when in_valid is high and in_stall is
// low; each request yields exactly one response on out_data (out_valid,
// out_stall). cfg_we writes the attribute used for new and blanked cells.
// Only one request is in work at a time; in_stall stays high until its
// response has been loaded into the output register.
// Sequence: a put without scroll, a read or an unused kind goes from the idle
// state to the result state and then loads its response. A clear or a put
// that scrolls first walks the whole grid, writing one cell per cycle; a
// scroll also reads, for each copied cell, the cell one row further on.
// Reset: the synchronous reset homes the cursor, sets the attribute to 0x0F
// and runs a clearing pass over the grid, during which in_stall is high;
// configuration writes are taken meanwhile.
// Stall: a held response keeps its value, and the next response waits in the
// sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tcw_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output tcw_out_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END     = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_POS = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);

  logic [15:0] mem [CELLS];

  tcw_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [7:0]        attr_r;
  logic              rd_hit_r, rd_hit_nxt;
  logic [15:0]       rd_data_r;

  logic              wr_v_r;
  logic              wr_copy_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [15:0]       wr_blank_r;

  logic              out_valid_r;
  tcw_out_t          out_r;

  logic              in_acc;
  logic              is_put;
  logic              is_nl;
  logic              wrap;
  logic              scroll;
  logic              sweep;
  logic              sweep_last;
  logic              copy;
  logic              load_out;
  logic [ADDR_W+10:0] idx_wide;
  logic [ADDR_W+10:0] pos_wide;
  logic              idx_hit;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  assign in_acc   = in_valid && !in_stall;
  assign is_put   = in_data.kind == KIND_PUT;
  assign is_nl    = in_data.char_code == NEWLINE_CODE;
  assign wrap     = is_nl || (col_r == LAST_COL);
  assign scroll   = is_put && wrap && (row_r == LAST_ROW);
  assign idx_wide = {ADDR_W'(0), in_data.cell_index};
  assign idx_hit  = idx_wide < (ADDR_W + 11)'(CELLS);
  assign pos_wide = {11'b0, pos_r};
  assign sweep    = (state_r == ST_INIT) || (state_r == ST_CLEAR) ||
                    (state_r == ST_SCROLL);
  assign sweep_last = cnt_r == LAST_CELL;
  assign copy     = (state_r == ST_SCROLL) && (cnt_r < COPY_END);
  assign load_out = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_data.kind == KIND_CLEAR) state_nxt = ST_CLEAR;
          else if (scroll)                         state_nxt = ST_SCROLL;
          else                                     state_nxt = ST_RESULT;
        end
      end
      ST_CLEAR, ST_SCROLL: begin
        if (sweep_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state_r != ST_IDLE) || wr_v_r;
    cnt_nxt   = sweep ? (sweep_last ? '0 : cnt_r + 1'b1) : '0;
    mem_re    = 1'b0;
    mem_raddr = idx_wide[ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = {attr_r, in_data.char_code};
    if (copy) begin
      mem_re    = 1'b1;
      mem_raddr = ADDR_W'(cnt_r + ADDR_W'(COLUMNS));
    end else if (in_acc && (in_data.kind == KIND_READ) && idx_hit) begin
      mem_re = 1'b1;
    end
    if (wr_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = wr_copy_r ? rd_data_r : wr_blank_r;
    end else if (in_acc && is_put && !is_nl) begin
      mem_we = 1'b1;
    end
  end

  // cursor update
  always_comb begin
    pos_nxt    = pos_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rd_hit_nxt = rd_hit_r;
    if (in_acc) begin
      rd_hit_nxt = (in_data.kind == KIND_READ) && idx_hit;
      unique case (in_data.kind)
        KIND_PUT: begin
          if (!wrap) begin
            col_nxt = col_r + 1'b1;
            pos_nxt = pos_r + 1'b1;
          end else if (row_r == LAST_ROW) begin
            col_nxt = '0;
            pos_nxt = LAST_ROW_POS;
          end else begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
            pos_nxt = ADDR_W'(pos_r - ADDR_W'(col_r) + ADDR_W'(COLUMNS));
          end
        end
        KIND_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
          pos_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      pos_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= RESET_ATTR;
      rd_hit_r    <= 1'b0;
      wr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rd_hit_r <= rd_hit_nxt;
      wr_v_r   <= sweep;
      if (cfg_we) attr_r <= cfg_wdata;
      if (load_out)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= cnt_r;
    wr_copy_r  <= copy;
    wr_blank_r <= {(state_r == ST_INIT) ? RESET_ATTR : attr_r, BLANK_CHAR};
    if (load_out) begin
      out_r.cursor_pos <= pos_wide[10:0];
      out_r.cell_char  <= rd_hit_r ? rd_data_r[7:0]  : 8'h00;
      out_r.cell_attr  <= rd_hit_r ? rd_data_r[15:8] : 8'h00;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_write_collision: assert property (@(posedge clk) disable iff (!rst_n)
    wr_v_r |-> in_stall)
    else $error("request taken while a sweep write is pending");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_CELL)
    else $error("cursor position beyond grid");

  a_pos_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |->
      (32'(pos_r) == 32'(row_r) * COLUMNS + 32'(col_r)))
    else $error("linear cursor out of step with row and column");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == ST_IDLE))
    else $error("response not loaded");

endmodule

`default_nettype wire
